// ===== rtl/core/sorted_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// consequent holds in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`else

`define SPQ_ASSERT_NOW(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int TAG_BITS_DEF = 16;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic load;
		logic rd_cur;
		logic rd_prev;
		logic wr_old;
		logic wr_new;
		logic idx_inc;
		logic idx_dec;
		logic mark;
		logic pop;
		logic push;
		logic resp_empty;
		logic resp_full;
	} spq_cmd_t;

	typedef struct packed {
		logic in_remove;
		logic op_remove;
		logic empty;
		logic full;
		logic ahead;
		logic idx_last;
		logic idx_at_pos;
	} spq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue of key/tag entries kept sorted in a ring memory
//
//   port group    dir   handshake
//   request       in    start & !busy: opcode, key, tag, batch_last
//   result        out   done strobe: out_valid, out_key, out_tag, status,
//                       occupancy
//   config        in    cfg_we: cfg_wdata (order_descending)
//
// remove reads the head entry, then pops it; refused requests answer from idle
// insert searches for its place, shifts the later entries back, then writes,
// or writes at once into an empty queue; the single memory port walks search then shift
// done is high one cycle; the receiver cannot stall
// reset clears the count; memory contents need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                opcode,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic [TAG_BITS-1:0] tag,
	input  wire logic                batch_last,
	output logic                     done,
	output logic                     out_valid,
	output logic [KEY_BITS-1:0]      out_key,
	output logic [TAG_BITS-1:0]      out_tag,
	output logic [1:0]               status,
	output logic [CW-1:0]            occupancy
);

`include "sorted_priority_queue_assert.svh"

	spq_pkg::spq_cmd_t  cmd;
	spq_pkg::spq_stat_t stat;
	logic               unused_batch;

	// batch end does not change ordering
	assign unused_batch = batch_last;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	spq_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.TAG_BITS (TAG_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.opcode    (opcode),
		.key       (key),
		.tag       (tag),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.out_valid (out_valid),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.status    (status),
		.occupancy (occupancy)
	);

	`SPQ_ASSERT_NOW(a_done_idle, done, !busy)
	`SPQ_ASSERT_NOW(a_valid_ok, done && out_valid, status == spq_pkg::STATUS_OK)
	`SPQ_ASSERT_NEXT(a_req_moves, start && !busy, done || busy)
	`SPQ_ASSERT_NOW(a_occ_bound, 1'b1, occupancy <= CW'(CAPACITY))

endmodule

`default_nettype wire

// ===== rtl/core/spq_dpath.sv =====
// ----------------------------------------------------------------------------
// spq_dpath
// entry memory kept as a ring, index counters, compare and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dpath #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int SW = CW + 1,
	localparam int WW = KEY_BITS + TAG_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 opcode,
	input  wire logic [KEY_BITS-1:0]  key,
	input  wire logic [TAG_BITS-1:0]  tag,
	input  wire spq_pkg::spq_cmd_t    cmd,
	output spq_pkg::spq_stat_t        stat,
	output logic                      done,
	output logic                      out_valid,
	output logic [KEY_BITS-1:0]       out_key,
	output logic [TAG_BITS-1:0]       out_tag,
	output logic [1:0]                status,
	output logic [CW-1:0]             occupancy
);

	logic [WW-1:0]       mem [CAPACITY];
	logic [WW-1:0]       rdata_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       pos_q;
	logic                order_q;
	logic                op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                done_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [1:0]          status_q;
	logic [CW-1:0]       lidx;
	logic [SW-1:0]       sum;
	logic [AW-1:0]       addr;
	logic [KEY_BITS-1:0] rkey;

	// logical index to ring address
	always_comb begin
		lidx = cmd.rd_prev ? idx_q - 1'b1 : idx_q;
		sum  = SW'(head_q) + SW'(lidx);
		if (sum >= SW'(CAPACITY)) begin
			sum = sum - SW'(CAPACITY);
		end
		addr = sum[AW-1:0];
	end

	assign rkey = rdata_q[WW-1:TAG_BITS];

	always_comb begin
		stat.in_remove  = (opcode == spq_pkg::OP_REMOVE);
		stat.op_remove  = (op_q == spq_pkg::OP_REMOVE);
		stat.empty      = (count_q == '0);
		stat.full       = (count_q >= CW'(CAPACITY));
		stat.ahead      = order_q ? (key_q >= rkey) : (key_q <= rkey);
		stat.idx_last   = (idx_q == count_q - 1'b1);
		stat.idx_at_pos = (idx_q == pos_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_cur || cmd.rd_prev) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_old) begin
			mem[addr] <= rdata_q;
		end else if (cmd.wr_new) begin
			mem[addr] <= {key_q, tag_q};
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= key;
			tag_q <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				pos_q <= '0;
			end else if (cmd.mark) begin
				pos_q <= stat.ahead ? idx_q : count_q;
				idx_q <= count_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - 1'b1;
			end
			if (cmd.pop) begin
				head_q  <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end else if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= spq_pkg::STATUS_OK;
		end else begin
			done_q      <= cmd.pop || cmd.push || cmd.resp_empty || cmd.resp_full;
			out_valid_q <= cmd.pop;
			if (cmd.resp_empty) begin
				status_q <= spq_pkg::STATUS_EMPTY;
			end else if (cmd.resp_full) begin
				status_q <= spq_pkg::STATUS_FULL;
			end else begin
				status_q <= spq_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_key_q <= rkey;
			out_tag_q <= rdata_q[TAG_BITS-1:0];
		end else begin
			out_key_q <= '0;
			out_tag_q <= '0;
		end
	end

	assign done      = done_q;
	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign status    = status_q;
	assign occupancy = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for one request: read and pop on remove; search, shift and write on insert
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_cmd_t       cmd,
	output logic                    busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_POP   = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_SHCHK = 3'd4;
	localparam logic [2:0] S_SHWR  = 3'd5;
	localparam logic [2:0] S_WNEW  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (stat.in_remove) begin
						if (stat.empty) begin
							cmd.resp_empty = 1'b1;
						end else begin
							cmd.load = 1'b1;
							state_d  = S_RD;
						end
					end else if (stat.full) begin
						cmd.resp_full = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = stat.empty ? S_WNEW : S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = stat.op_remove ? S_POP : S_CMP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_IDLE;
			end
			S_CMP: begin
				if (stat.ahead || stat.idx_last) begin
					cmd.mark = 1'b1;
					state_d  = S_SHCHK;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_SHCHK: begin
				if (stat.idx_at_pos) begin
					state_d = S_WNEW;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.wr_old  = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_SHCHK;
			end
			S_WNEW: begin
				cmd.wr_new = 1'b1;
				cmd.push   = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire
